// ----- rtl/tilt_fusion_pd_balance_assert.svh -----
// Assertion macros shared by the tilt fusion RTL.
// Users must provide clk and arst_n in scope.
`ifndef TILT_FUSION_PD_BALANCE_ASSERT_SVH
`define TILT_FUSION_PD_BALANCE_ASSERT_SVH

// same-cycle implication
`define TFPB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TFPB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tfpb_pkg.sv -----
// Shared types and constants for the tilt fusion PD balance block.
// No dependencies.
`timescale 1ns / 1ps
package tfpb_pkg;

	localparam int PADDR_W   = 5;
	localparam int GAIN_W    = 16;
	localparam int DIGIT_W   = 4;
	localparam int MUL_X_W   = 23;
	localparam int MUL_Q_W   = 32;
	localparam int MUL_ACC_W = MUL_X_W + DIGIT_W + 1;

	localparam logic signed [12:0] ACCEL_OFFSET = 13'sd2048;

	localparam logic [11:0]        RST_GYRO_ZERO = 12'd2048;
	localparam logic signed [15:0] RST_GAIN      = 16'sd256;
	localparam logic signed [15:0] RST_DRIVE_MAX = 16'sh7fff;
	localparam logic signed [15:0] RST_DRIVE_MIN = 16'sh8000;

	typedef enum logic [2:0] {
		REG_GYRO_ZERO  = 3'd0,
		REG_ACCEL_GAIN = 3'd1,
		REG_GYRO_GAIN  = 3'd2,
		REG_FUSE_GAIN  = 3'd3,
		REG_P_GAIN     = 3'd4,
		REG_D_GAIN     = 3'd5,
		REG_DRIVE_MAX  = 3'd6,
		REG_DRIVE_MIN  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]        gyro_zero;
		logic signed [15:0] accel_gain;
		logic signed [15:0] gyro_gain;
		logic signed [15:0] fuse_gain;
		logic signed [15:0] p_gain;
		logic signed [15:0] d_gain;
		logic signed [15:0] drive_max;
		logic signed [15:0] drive_min;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

// ----- rtl/tilt_fusion_pd_balance.sv -----
// Tilt fusion PD balance: complementary filter angle estimate and clamped PD drive.
// A new input request is accepted only once the previous one has left the sequencer,
// as its five products run in turn through one 4-bit digit-serial multiplier.
// A waiting result does not block the next input request.
// arst_n clears the angle sum, the sequencer and the registers to their defaults.
// Depends on tfpb_pkg, tfpb_apb_regs, tfpb_digit_mul, tilt_fusion_pd_balance_assert.svh.
`timescale 1ns / 1ps
`include "tilt_fusion_pd_balance_assert.svh"
module tilt_fusion_pd_balance (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tfpb_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [11:0]                  accel_sample,
	input  logic [11:0]                  gyro_sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [15:0]           drive,
	output logic signed [21:0]           angle_estimate
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_SUM  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		OP_ACCEL = 3'd0,
		OP_RATE  = 3'd1,
		OP_CORR  = 3'd2,
		OP_PTERM = 3'd3,
		OP_DTERM = 3'd4
	} op_t;

	tfpb_pkg::cfg_t      cfg;
	tfpb_pkg::mul_stat_t mul_stat;

	state_t state_q;
	op_t    op_q;
	logic   start_q;
	logic   out_valid_q;

	logic signed [31:0] sum_q;
	logic signed [12:0] a_q;
	logic signed [12:0] g_q;
	logic signed [21:0] angle_q;
	logic signed [19:0] accel_q;
	logic signed [19:0] rate_q;
	logic signed [30:0] corr_q;
	logic signed [29:0] pterm_q;
	logic signed [22:0] dterm_q;
	logic signed [30:0] pd_q;
	logic signed [15:0] drive_q;
	logic signed [21:0] angle_out_q;

	logic signed [12:0] a_in;
	logic signed [12:0] g_in;
	logic signed [21:0] angle_in;
	logic               in_acc;
	logic               out_free;

	logic signed [tfpb_pkg::MUL_X_W-1:0] mul_x;
	logic signed [tfpb_pkg::GAIN_W-1:0]  mul_gain;
	logic signed [tfpb_pkg::MUL_Q_W-1:0] mul_q;

	logic signed [33:0] nxt;
	logic signed [31:0] nxt_sat;
	logic signed [30:0] dmax;
	logic signed [30:0] dmin;
	logic signed [15:0] drive_cl;

	tfpb_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tfpb_digit_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.x      (mul_x),
		.gain   (mul_gain),
		.q      (mul_q),
		.stat   (mul_stat)
	);

	assign a_in     = $signed({1'b0, accel_sample}) - tfpb_pkg::ACCEL_OFFSET;
	assign g_in     = $signed({1'b0, gyro_sample}) - $signed({1'b0, cfg.gyro_zero});
	assign angle_in = sum_q[31:10] + {21'd0, (sum_q[31] && (sum_q[9:0] != '0))};

	assign in_ready       = (state_q == S_IDLE);
	assign in_acc         = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign out_free       = !out_valid_q || out_ready;
	assign drive          = drive_q;
	assign angle_estimate = angle_out_q;

	always_comb begin
		case (op_q)
			OP_ACCEL: begin
				mul_x    = 23'(a_q);
				mul_gain = $signed(cfg.accel_gain);
			end
			OP_RATE: begin
				mul_x    = 23'(g_q);
				mul_gain = $signed(cfg.gyro_gain);
			end
			OP_CORR: begin
				mul_x    = 23'(accel_q) - 23'(angle_q);
				mul_gain = $signed(cfg.fuse_gain);
			end
			OP_PTERM: begin
				mul_x    = 23'(angle_q);
				mul_gain = $signed(cfg.p_gain);
			end
			OP_DTERM: begin
				mul_x    = 23'(rate_q >>> 5);
				mul_gain = $signed(cfg.d_gain);
			end
			default: begin
				mul_x    = '0;
				mul_gain = '0;
			end
		endcase
	end

	assign nxt     = 34'(sum_q) + 34'(rate_q) + 34'(corr_q);
	assign nxt_sat = (nxt[33:31] == 3'b000 || nxt[33:31] == 3'b111) ? nxt[31:0] :
		(nxt[33] ? 32'sh80000000 : 32'sh7fffffff);

	assign dmax     = 31'($signed(cfg.drive_max));
	assign dmin     = 31'($signed(cfg.drive_min));
	assign drive_cl = (pd_q > dmax) ? $signed(cfg.drive_max) :
		((pd_q < dmin) ? $signed(cfg.drive_min) : pd_q[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ACCEL;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else begin
			start_q <= in_acc || (state_q == S_MUL && mul_stat.done && op_q != OP_DTERM);
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q    <= OP_ACCEL;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_stat.done) begin
						if (op_q == OP_DTERM) begin
							state_q <= S_SUM;
						end else begin
							op_q <= op_t'(op_q + 3'd1);
						end
					end
				end
				S_SUM: begin
					sum_q   <= nxt_sat;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q     <= a_in;
			g_q     <= g_in;
			angle_q <= angle_in;
		end
		if (state_q == S_MUL && mul_stat.done) begin
			case (op_q)
				OP_ACCEL: accel_q <= mul_q[19:0];
				OP_RATE:  rate_q  <= mul_q[19:0];
				OP_CORR:  corr_q  <= mul_q[30:0];
				OP_PTERM: pterm_q <= mul_q[29:0];
				OP_DTERM: dterm_q <= mul_q[22:0];
				default: ;
			endcase
		end
		if (state_q == S_SUM)
			pd_q <= 31'(pterm_q) + 31'(dterm_q);
		if (state_q == S_OUT && out_free) begin
			drive_q     <= drive_cl;
			angle_out_q <= angle_q;
		end
	end

	`TFPB_ASSERT_IMP(a_start_idle, start_q, !mul_stat.busy, "multiplier started while busy")
	`TFPB_ASSERT_IMP(a_done_in_mul, mul_stat.done, state_q == S_MUL, "product outside MUL")
	`TFPB_ASSERT_IMP(a_op_range, state_q == S_MUL, op_q <= OP_DTERM, "product index out of range")
	`TFPB_ASSERT_NXT(a_sum_to_out, state_q == S_SUM, state_q == S_OUT, "SUM not followed by OUT")
	`TFPB_ASSERT_NXT(a_out_load, state_q == S_OUT && out_free, out_valid_q && in_ready,
		"result not loaded on free slot")

endmodule

// ----- rtl/tfpb_apb_regs.sv -----
// APB configuration registers for the tilt fusion PD balance block.
// Depends on tfpb_pkg.
`timescale 1ns / 1ps
module tfpb_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tfpb_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output tfpb_pkg::cfg_t               cfg
);

	tfpb_pkg::cfg_t     cfg_q;
	tfpb_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = tfpb_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gyro_zero  <= tfpb_pkg::RST_GYRO_ZERO;
			cfg_q.accel_gain <= tfpb_pkg::RST_GAIN;
			cfg_q.gyro_gain  <= tfpb_pkg::RST_GAIN;
			cfg_q.fuse_gain  <= tfpb_pkg::RST_GAIN;
			cfg_q.p_gain     <= tfpb_pkg::RST_GAIN;
			cfg_q.d_gain     <= tfpb_pkg::RST_GAIN;
			cfg_q.drive_max  <= tfpb_pkg::RST_DRIVE_MAX;
			cfg_q.drive_min  <= tfpb_pkg::RST_DRIVE_MIN;
		end else if (wr_en) begin
			case (idx)
				tfpb_pkg::REG_GYRO_ZERO:  cfg_q.gyro_zero  <= pwdata[11:0];
				tfpb_pkg::REG_ACCEL_GAIN: cfg_q.accel_gain <= pwdata[15:0];
				tfpb_pkg::REG_GYRO_GAIN:  cfg_q.gyro_gain  <= pwdata[15:0];
				tfpb_pkg::REG_FUSE_GAIN:  cfg_q.fuse_gain  <= pwdata[15:0];
				tfpb_pkg::REG_P_GAIN:     cfg_q.p_gain     <= pwdata[15:0];
				tfpb_pkg::REG_D_GAIN:     cfg_q.d_gain     <= pwdata[15:0];
				tfpb_pkg::REG_DRIVE_MAX:  cfg_q.drive_max  <= pwdata[15:0];
				tfpb_pkg::REG_DRIVE_MIN:  cfg_q.drive_min  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tfpb_pkg::REG_GYRO_ZERO:  prdata = {20'd0, cfg_q.gyro_zero};
			tfpb_pkg::REG_ACCEL_GAIN: prdata = {{16{cfg_q.accel_gain[15]}}, cfg_q.accel_gain};
			tfpb_pkg::REG_GYRO_GAIN:  prdata = {{16{cfg_q.gyro_gain[15]}}, cfg_q.gyro_gain};
			tfpb_pkg::REG_FUSE_GAIN:  prdata = {{16{cfg_q.fuse_gain[15]}}, cfg_q.fuse_gain};
			tfpb_pkg::REG_P_GAIN:     prdata = {{16{cfg_q.p_gain[15]}}, cfg_q.p_gain};
			tfpb_pkg::REG_D_GAIN:     prdata = {{16{cfg_q.d_gain[15]}}, cfg_q.d_gain};
			tfpb_pkg::REG_DRIVE_MAX:  prdata = {{16{cfg_q.drive_max[15]}}, cfg_q.drive_max};
			tfpb_pkg::REG_DRIVE_MIN:  prdata = {{16{cfg_q.drive_min[15]}}, cfg_q.drive_min};
			default:                  prdata = '0;
		endcase
	end

endmodule

// ----- rtl/tfpb_digit_mul.sv -----
// Digit-serial signed Q8.8 multiplier: one 4-bit gain digit per cycle,
// product divided by 256 truncating toward zero. Depends on tfpb_pkg.
`timescale 1ns / 1ps
module tfpb_digit_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tfpb_pkg::MUL_X_W-1:0] x,
	input  logic signed [tfpb_pkg::GAIN_W-1:0]  gain,
	output logic signed [tfpb_pkg::MUL_Q_W-1:0] q,
	output tfpb_pkg::mul_stat_t                 stat
);

	localparam int ACC_W  = tfpb_pkg::MUL_ACC_W;
	localparam int DIG_W  = tfpb_pkg::DIGIT_W;
	localparam int GAIN_W = tfpb_pkg::GAIN_W;
	localparam int NDIG   = GAIN_W / DIG_W;
	localparam int CNT_W  = $clog2(NDIG);
	localparam int SH_W   = ACC_W + GAIN_W - 8;

	logic signed [tfpb_pkg::MUL_X_W-1:0] x_q;
	logic [GAIN_W-1:0]                   gsr_q;
	logic signed [ACC_W-1:0]             acc_q;
	logic [GAIN_W-1:0]                   lo_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic                                busy_q;
	logic                                fix_q;

	logic                    last;
	logic signed [DIG_W:0]   dig;
	logic signed [ACC_W-1:0] pp;
	logic signed [ACC_W-1:0] psum;
	logic [SH_W-1:0]         prod_sh;
	logic [SH_W-1:0]         prod_rnd;

	assign last = (cnt_q == CNT_W'(NDIG - 1));
	assign dig  = last ? {gsr_q[DIG_W-1], gsr_q[DIG_W-1:0]} : {1'b0, gsr_q[DIG_W-1:0]};
	assign pp   = ACC_W'(x_q) * ACC_W'(dig);
	assign psum = acc_q + pp;

	assign prod_sh  = {acc_q, lo_q[GAIN_W-1:8]};
	assign prod_rnd = prod_sh + SH_W'(acc_q[ACC_W-1] && (lo_q[7:0] != '0));
	assign q        = prod_rnd[tfpb_pkg::MUL_Q_W-1:0];

	assign stat.busy = busy_q || fix_q;
	assign stat.done = fix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fix_q <= !start && busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			gsr_q <= gain;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= psum >>> DIG_W;
			lo_q  <= {psum[DIG_W-1:0], lo_q[GAIN_W-1:DIG_W]};
			gsr_q <= gsr_q >> DIG_W;
		end
	end

endmodule

// ----- tb/tb_tilt_fusion_pd_balance.sv -----
// Self-checking bench for tilt_fusion_pd_balance: a typed-in table of ticks, then random
// ticks under fixed, then random register sets; results checked against typed values or a
// local predictor. Depends on tfpb_pkg and the tilt_fusion_pd_balance RTL.
`timescale 1ns / 1ps
module tb_tilt_fusion_pd_balance;

	localparam int     RANDOM_TICKS  = 830;
	localparam int     IDLE_PCT      = 30;
	localparam int     CALM_FROM     = 250;
	localparam int     CALM_TO       = 350;
	localparam int     HOLD_AT       = 600;
	localparam int     HOLD_CYCLES   = 600;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     CYCLE_LIMIT   = 400000;
	localparam longint SUM_MAX       = 64'sd2147483647;
	localparam longint SUM_MIN       = -64'sd2147483648;

	typedef struct {
		logic signed [15:0] drive;
		logic signed [21:0] angle;
	} tick_result_t;

	typedef struct {
		int                 cfg_set;
		logic [11:0]        accel;
		logic [11:0]        gyro;
		bit                 typed;
		logic signed [15:0] drive;
		logic signed [21:0] angle;
	} tick_row_t;

	localparam int DIR_ROWS = 23;

	// set 0: reset values; set 1: diverging filter with crossed drive limits
	tick_row_t dir_rows [DIR_ROWS] = '{
		'{0, 12'd2048, 12'd2048, 1'b1, 16'sd0,    22'sd0},
		'{0, 12'd0,    12'd0,    1'b1, -16'sd64,  22'sd0},
		'{0, 12'd4095, 12'd4095, 1'b1, 16'sd59,   -22'sd4},
		'{1, 12'd4095, 12'd4095, 1'b1, 16'sd2000, 22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd2048, 1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd4095, 1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd1024, 1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0},
		'{1, 12'd4095, 12'd0,    1'b0, 16'sd0,    22'sd0}
	};

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         psel         = 1'b0;
	logic                         penable      = 1'b0;
	logic                         pwrite       = 1'b0;
	logic [tfpb_pkg::PADDR_W-1:0] paddr        = '0;
	logic [31:0]                  pwdata       = '0;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         in_valid     = 1'b0;
	logic                         in_ready;
	logic [11:0]                  accel_sample = '0;
	logic [11:0]                  gyro_sample  = '0;
	logic                         out_valid;
	logic                         out_ready    = 1'b0;
	logic signed [15:0]           drive;
	logic signed [21:0]           angle_estimate;

	tfpb_pkg::cfg_t tilt_cfg = '{tfpb_pkg::RST_GYRO_ZERO, tfpb_pkg::RST_GAIN,
	                             tfpb_pkg::RST_GAIN, tfpb_pkg::RST_GAIN, tfpb_pkg::RST_GAIN,
	                             tfpb_pkg::RST_GAIN, tfpb_pkg::RST_DRIVE_MAX,
	                             tfpb_pkg::RST_DRIVE_MIN};
	longint       angle_sum = 0;
	tick_result_t pending_ticks [$];
	tick_result_t head_tick;
	int           mismatches = 0;
	int           ticks_sent = 0;
	int           cycle_cnt  = 0;
	int           hold_left  = 0;
	bit           hold_done  = 1'b0;
	bit           calm       = 1'b0;

	tilt_fusion_pd_balance u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.accel_sample   (accel_sample),
		.gyro_sample    (gyro_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive          (drive),
		.angle_estimate (angle_estimate)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint scale_q88(longint x, longint gain);
		return (x * gain) / 256;
	endfunction

	function automatic tick_result_t advance_tilt(logic [11:0] acc, logic [11:0] gyr);
		longint       accel_v;
		longint       rate_v;
		longint       angle_v;
		longint       corr_v;
		longint       next_sum;
		longint       pd_v;
		tick_result_t res;
		accel_v  = scale_q88(longint'(acc) - longint'(tfpb_pkg::ACCEL_OFFSET),
		                     tilt_cfg.accel_gain);
		rate_v   = scale_q88(longint'(gyr) - longint'(tilt_cfg.gyro_zero), tilt_cfg.gyro_gain);
		angle_v  = angle_sum / 1024;
		corr_v   = scale_q88(accel_v - angle_v, tilt_cfg.fuse_gain);
		next_sum = angle_sum + rate_v + corr_v;
		if (next_sum > SUM_MAX)
			next_sum = SUM_MAX;
		else if (next_sum < SUM_MIN)
			next_sum = SUM_MIN;
		angle_sum = next_sum;
		pd_v = scale_q88(angle_v, tilt_cfg.p_gain) + scale_q88(rate_v >>> 5, tilt_cfg.d_gain);
		if (pd_v > longint'(tilt_cfg.drive_max))
			pd_v = tilt_cfg.drive_max;
		else if (pd_v < longint'(tilt_cfg.drive_min))
			pd_v = tilt_cfg.drive_min;
		res.drive = pd_v[15:0];
		res.angle = angle_v[21:0];
		return res;
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3, 4, 5, 6: return 16'($urandom_range(0, 1024)) - 16'd512;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_reg_value(tfpb_pkg::reg_idx_t r, int set_idx);
		if (set_idx == 0)
			return (r == tfpb_pkg::REG_GYRO_ZERO || r == tfpb_pkg::REG_DRIVE_MIN) ?
			       16'h0000 : 16'h7fff;
		if (set_idx == 1)
			return (r == tfpb_pkg::REG_GYRO_ZERO) ? 16'h0fff :
			       (r == tfpb_pkg::REG_DRIVE_MIN) ? 16'h7fff : 16'h8000;
		case (r)
			tfpb_pkg::REG_GYRO_ZERO:
				return ($urandom_range(0, 9) < 5) ? 16'($urandom_range(1948, 2148))
				                                  : 16'($urandom_range(0, 4095));
			tfpb_pkg::REG_FUSE_GAIN:
				return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 96)) : pick_gain();
			tfpb_pkg::REG_DRIVE_MAX:
				return ($urandom_range(0, 3) == 0) ? 16'h7fff : 16'($urandom);
			tfpb_pkg::REG_DRIVE_MIN:
				return ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'($urandom);
			default:
				return pick_gain();
		endcase
	endfunction

	function automatic logic [11:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 12'($urandom_range(0, 4095));
		if (r < 85)
			return 12'($urandom_range(1984, 2112));
		return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
	endfunction

	task automatic write_cfg(tfpb_pkg::reg_idx_t r, logic [15:0] val);
		logic [31:0] byte_addr;
		logic [31:0] mask;
		logic [31:0] wdata;
		byte_addr = r * 4;
		mask      = (r == tfpb_pkg::REG_GYRO_ZERO) ? 32'h0000_0fff : 32'h0000_ffff;
		wdata     = (r == tfpb_pkg::REG_GYRO_ZERO) ? {20'h0, val[11:0]} :
		            {{16{val[15]}}, val};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= byte_addr[tfpb_pkg::PADDR_W-1:0];
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (r)
			tfpb_pkg::REG_GYRO_ZERO:  tilt_cfg.gyro_zero  = val[11:0];
			tfpb_pkg::REG_ACCEL_GAIN: tilt_cfg.accel_gain = val;
			tfpb_pkg::REG_GYRO_GAIN:  tilt_cfg.gyro_gain  = val;
			tfpb_pkg::REG_FUSE_GAIN:  tilt_cfg.fuse_gain  = val;
			tfpb_pkg::REG_P_GAIN:     tilt_cfg.p_gain     = val;
			tfpb_pkg::REG_D_GAIN:     tilt_cfg.d_gain     = val;
			tfpb_pkg::REG_DRIVE_MAX:  tilt_cfg.drive_max  = val;
			tfpb_pkg::REG_DRIVE_MIN:  tilt_cfg.drive_min  = val;
			default: ;
		endcase
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (wdata & mask)) begin
			$error("prdata of %s: expected %0h, actual %0h", r.name(), wdata & mask,
			       prdata & mask);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_ticks();
		in_valid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_tick(logic [11:0] acc, logic [11:0] gyr, bit typed,
	                         tick_result_t typed_res);
		tick_result_t res;
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		accel_sample <= acc;
		gyro_sample  <= gyr;
		do
			@(posedge clk);
		while (!in_ready);
		ticks_sent++;
		res = advance_tilt(acc, gyr);
		pending_ticks.push_back(typed ? typed_res : res);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && ticks_sent >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
		if (out_valid && out_ready) begin
			if (pending_ticks.size() == 0) begin
				$error("unexpected result: drive %0d, angle_estimate %0d", drive, angle_estimate);
				mismatches++;
			end else begin
				head_tick = pending_ticks.pop_front();
				if (drive !== head_tick.drive) begin
					$error("drive: expected %0d, actual %0d", head_tick.drive, drive);
					mismatches++;
				end
				if (angle_estimate !== head_tick.angle) begin
					$error("angle_estimate: expected %0d, actual %0d", head_tick.angle,
					       angle_estimate);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int           cur_set;
		int           set_idx;
		int           rnd_sent;
		int           set_len;
		tick_result_t typed_res;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_set = 0;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].cfg_set != cur_set) begin
				drain_ticks();
				write_cfg(tfpb_pkg::REG_GYRO_ZERO, 16'h0fff);
				write_cfg(tfpb_pkg::REG_ACCEL_GAIN, 16'h7fff);
				write_cfg(tfpb_pkg::REG_GYRO_GAIN, 16'h7fff);
				write_cfg(tfpb_pkg::REG_FUSE_GAIN, 16'h8000);
				write_cfg(tfpb_pkg::REG_P_GAIN, 16'h8000);
				write_cfg(tfpb_pkg::REG_D_GAIN, 16'h7fff);
				write_cfg(tfpb_pkg::REG_DRIVE_MAX, 16'd1000);
				write_cfg(tfpb_pkg::REG_DRIVE_MIN, 16'd2000);
				cur_set = dir_rows[i].cfg_set;
			end
			typed_res.drive = dir_rows[i].drive;
			typed_res.angle = dir_rows[i].angle;
			push_tick(dir_rows[i].accel, dir_rows[i].gyro, dir_rows[i].typed, typed_res);
		end

		rnd_sent = 0;
		set_idx  = 0;
		while (rnd_sent < RANDOM_TICKS) begin
			drain_ticks();
			for (int r = 0; r < 8; r++) begin
				if (set_idx < 2 || $urandom_range(0, 9) < 7)
					write_cfg(tfpb_pkg::reg_idx_t'(r[2:0]),
					          pick_reg_value(tfpb_pkg::reg_idx_t'(r[2:0]), set_idx));
			end
			set_len = $urandom_range(40, 100);
			repeat (set_len) begin
				calm = (rnd_sent >= CALM_FROM && rnd_sent < CALM_TO);
				push_tick(pick_sample(), pick_sample(), 1'b0, typed_res);
				rnd_sent++;
			end
			set_idx++;
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tfpb_pkg.sv
rtl/tfpb_apb_regs.sv
rtl/tfpb_digit_mul.sv
rtl/tilt_fusion_pd_balance.sv
tb/tb_tilt_fusion_pd_balance.sv
